[hdl/spfg_pkg.sv]
// ----------------------------------------------------------------------------
// spfg_pkg: servo pulse frame generator definitions
// Request types, command and register codes, width conversion helpers.
// ----------------------------------------------------------------------------
package spfg_pkg;

    localparam int CHANNELS_DEF = 4;
    localparam int PULSE_FIELDS = 4;   // channels carried by a set-pulses request
    localparam int PIN_W        = 4;   // width of the pin_levels field
    localparam int WIDTH_W      = 12;
    localparam int POS_W        = 16;
    localparam int ENABLE_W     = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;

    localparam logic [WIDTH_W-1:0] MIN_WIDTH = 12'd500;
    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 12'd2500;
    localparam logic [7:0]         MAX_ANGLE = 8'd180;
    // floor(a * 100 / 9) == (a * ANGLE_RECIP) >> 16 for a in 0..180
    localparam int                 ANGLE_RECIP_W = 20;
    localparam logic [ANGLE_RECIP_W-1:0] ANGLE_RECIP = 20'd728200;

    localparam logic [POS_W-1:0]    PERIOD_RST = 16'd19999;
    localparam logic [ENABLE_W-1:0] ENABLE_RST = 4'hF;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_PULSES = 2'd1,
        CMD_ANGLE  = 2'd2
    } t_cmd;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PERIOD = 2'd0,
        CFG_ENABLE = 2'd1
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [7:0]         channel;
        logic [7:0]         angle_deg;
        logic signed [15:0] pulse_a;
        logic signed [15:0] pulse_b;
        logic signed [15:0] pulse_c;
        logic signed [15:0] pulse_d;
    } t_in_req;

    typedef struct packed {
        logic [PIN_W-1:0] pin_levels;
        logic             frame_start;
    } t_out_req;

    // Nonpositive turns the channel off, else clamp to 500..2500.
    function automatic logic [WIDTH_W-1:0] width_from_pulse(logic signed [15:0] p);
        logic [WIDTH_W-1:0] w;
        if (p <= 16'sd0) begin
            w = '0;
        end else if (p < 16'sd500) begin
            w = MIN_WIDTH;
        end else if (p > 16'sd2500) begin
            w = MAX_WIDTH;
        end else begin
            w = p[WIDTH_W-1:0];
        end
        return w;
    endfunction

    function automatic logic [WIDTH_W-1:0] width_from_angle(logic [7:0] angle);
        logic [7:0]                    a;
        logic [ANGLE_RECIP_W+7:0]      prod;
        a    = (angle > MAX_ANGLE) ? MAX_ANGLE : angle;
        prod = {{ANGLE_RECIP_W{1'b0}}, a} * {8'd0, ANGLE_RECIP};
        return MIN_WIDTH + prod[ANGLE_RECIP_W+7:16];
    endfunction

endpackage

[hdl/servo_pulse_frame_generator.sv]
// ----------------------------------------------------------------------------
// servo_pulse_frame_generator
// Multi-channel servo pulse generator driven by microsecond tick requests.
// ----------------------------------------------------------------------------
// Pipeline: an accepted request passes the input register, then the result
//   register. Throughput: one request per cycle unless the result channel stalls;
//   all channel compares run in parallel.
// Reset (synchronous, active low): all widths off, frame position zero so the
//   next tick starts a frame, pins low, period 19999, all channels enabled.
module servo_pulse_frame_generator #(
    parameter int CHANNELS = spfg_pkg::CHANNELS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request channel
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  spfg_pkg::t_in_req                i_in_req,
    // result channel
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output spfg_pkg::t_out_req               o_out_req,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [spfg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [spfg_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WIDTH_W = spfg_pkg::WIDTH_W;
    localparam int POS_W   = spfg_pkg::POS_W;
    // channels reachable by pulses, enable bits and the pin field
    localparam int PF_LIM  = (CHANNELS < spfg_pkg::PULSE_FIELDS) ?
                             CHANNELS : spfg_pkg::PULSE_FIELDS;
    localparam int EN_LIM  = (CHANNELS < spfg_pkg::ENABLE_W) ? CHANNELS : spfg_pkg::ENABLE_W;
    localparam int PIN_LIM = (CHANNELS < spfg_pkg::PIN_W) ? CHANNELS : spfg_pkg::PIN_W;

    // ---------------- handshake / pipeline control ----------------
    logic               r_s1_vld;
    spfg_pkg::t_in_req  r_s1_req;
    logic               r_out_vld;
    spfg_pkg::t_out_req r_out;
    logic               w_s1_move;

    // stage 1 moves into the result register when that one is free or draining
    assign w_s1_move   = r_s1_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_s1_vld || w_s1_move;
    assign o_out_valid = r_out_vld;
    assign o_out_req   = r_out;
    assign o_cfg_ready = 1'b1;   // registers are plain flops, always writable

    // ---------------- configuration registers ----------------
    logic [POS_W-1:0]                r_period;
    logic [spfg_pkg::ENABLE_W-1:0]   r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= spfg_pkg::PERIOD_RST;
            r_enable <= spfg_pkg::ENABLE_RST;
        end else if (i_cfg_valid) begin
            unique case (spfg_pkg::t_cfg_idx'(i_cfg_index))
                spfg_pkg::CFG_PERIOD: r_period <= i_cfg_data;
                spfg_pkg::CFG_ENABLE: r_enable <= i_cfg_data[spfg_pkg::ENABLE_W-1:0];
                default: ;   // unmapped index: write dropped
            endcase
        end
    end

    // ---------------- generator state ----------------
    logic [CHANNELS-1:0][WIDTH_W-1:0] r_set_w,   n_set_w;
    logic [CHANNELS-1:0][WIDTH_W-1:0] r_frame_w, n_frame_w;
    logic [POS_W-1:0]                 r_pos,     n_pos;
    logic [CHANNELS-1:0]              r_pin,     n_pin;
    logic                             n_start;
    spfg_pkg::t_out_req               n_out;

    logic [CHANNELS-1:0]                         w_en;
    logic [spfg_pkg::PULSE_FIELDS-1:0][15:0]     w_pulse;
    logic [WIDTH_W-1:0]                          w_angle_w;

    // enable bits mapped onto channels; channels past the enable field stay off
    always_comb begin
        w_en = '0;
        for (int i = 0; i < EN_LIM; i++) begin
            w_en[i] = r_enable[i];
        end
    end

    always_comb begin
        w_pulse[0] = r_s1_req.pulse_a;
        w_pulse[1] = r_s1_req.pulse_b;
        w_pulse[2] = r_s1_req.pulse_c;
        w_pulse[3] = r_s1_req.pulse_d;
    end

    assign w_angle_w = spfg_pkg::width_from_angle(r_s1_req.angle_deg);

    always_comb begin
        n_set_w   = r_set_w;
        n_frame_w = r_frame_w;
        n_pos     = r_pos;
        n_pin     = r_pin;
        n_start   = 1'b0;
        case (spfg_pkg::t_cmd'(r_s1_req.cmd))
            spfg_pkg::CMD_TICK: begin
                // frame start: latch the widths and raise enabled, nonzero channels
                if (r_pos == '0) begin
                    n_start   = 1'b1;
                    n_frame_w = r_set_w;
                    for (int i = 0; i < CHANNELS; i++) begin
                        n_pin[i] = w_en[i] && (r_set_w[i] != '0);
                    end
                end
                // drop each pin on the tick its width is reached
                for (int i = 0; i < CHANNELS; i++) begin
                    if (n_frame_w[i] != '0 &&
                        {{(POS_W-WIDTH_W){1'b0}}, n_frame_w[i]} == r_pos) begin
                        n_pin[i] = 1'b0;
                    end
                end
                n_pos = (r_pos == r_period) ? '0 : r_pos + 1'b1;
            end
            spfg_pkg::CMD_PULSES: begin
                for (int i = 0; i < PF_LIM; i++) begin
                    n_set_w[i] = spfg_pkg::width_from_pulse(w_pulse[i]);
                end
            end
            spfg_pkg::CMD_ANGLE: begin
                // out-of-range channel matches nothing and is ignored
                for (int i = 0; i < CHANNELS; i++) begin
                    if (r_s1_req.channel == 8'(i)) begin
                        n_set_w[i] = w_angle_w;
                    end
                end
            end
            default: ;   // unused command: report only
        endcase
    end

    always_comb begin
        n_out.pin_levels  = '0;
        n_out.frame_start = n_start;
        for (int i = 0; i < PIN_LIM; i++) begin
            n_out.pin_levels[i] = n_pin[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_set_w   <= '0;
            r_frame_w <= '0;
            r_pos     <= '0;
            r_pin     <= '0;
        end else begin
            if (o_in_ready) begin
                r_s1_vld <= i_in_valid;
            end
            if (w_s1_move) begin
                r_out_vld <= 1'b1;
                r_set_w   <= n_set_w;
                r_frame_w <= n_frame_w;
                r_pos     <= n_pos;
                r_pin     <= n_pin;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_s1_req <= i_in_req;
        end
        if (w_s1_move) begin
            r_out <= n_out;
        end
    end

endmodule

[hdl/spfg_checker.sv]
// ----------------------------------------------------------------------------
// spfg_checker
// Port-level checks for the servo pulse frame generator, bound to the top.
// ----------------------------------------------------------------------------
module spfg_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_ready,
    input logic                             o_out_valid,
    input logic                             i_out_ready,
    input spfg_pkg::t_out_req               o_out_req,
    input logic                             o_cfg_ready
);

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // every accepted request is followed by a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("accepted request produced no result");

    // register port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cfg_ready)
        else $error("config port not ready");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_req)))
        else $error("stalled result changed");

endmodule

bind servo_pulse_frame_generator spfg_checker u_spfg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_req   (o_out_req),
    .o_cfg_ready (o_cfg_ready)
);
